// ===== rtl/core/jcse_pkg.sv =====
// ============================================================================
// jcse_pkg: shared types, constants and helpers
// Character codes, result kinds, queue sizes and the byte classifier used by
// both the front and the back of the content string extractor.
// ============================================================================
package jcse_pkg;

  // Queue sizes (powers of two)
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam logic [FQ_AW:0] FQ_FULL = (FQ_AW + 1)'(FQ_DEPTH);
  localparam logic [OQ_AW:0] OQ_FULL = (OQ_AW + 1)'(OQ_DEPTH);

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;
  localparam logic [1:0] KIND_BAD  = 2'd3;

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_LC_C   = 8'h63;
  localparam logic [7:0] CH_LC_O   = 8'h6F;
  localparam logic [7:0] CH_LC_E   = 8'h65;

  // Key "content" with its quotes
  localparam logic [3:0] KEY_LEN = 4'd9;

  // Per-transaction result limit
  localparam logic [2:0] RES_CAP = 3'd6;

  // UTF-8 encoding
  localparam logic [15:0] CP_ONE    = 16'h0080;
  localparam logic [15:0] CP_TWO    = 16'h0800;
  localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF_CONT  = 8'h80;
  localparam logic [7:0]  UTF_MASK  = 8'h3F;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_zero;
    logic       is_quote;
    logic       is_bslash;
    logic       is_colon;
    logic       is_space;
    logic [3:0] hexv;
  } cls_t;

  typedef struct packed {
    cls_t cls;
    logic is_end;
  } fitem_t;

  typedef struct packed {
    logic   valid;
    fitem_t item;
  } fq_rd_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } res_t;

  typedef struct packed {
    logic push;
    res_t res;
    logic last;
  } oq_wr_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r.ch        = c;
    r.is_zero   = (c == 8'h00);
    r.is_quote  = (c == CH_QUOTE);
    r.is_bslash = (c == CH_BSLASH);
    r.is_colon  = (c == CH_COLON);
    r.is_space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      r.hexv = c[3:0];
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      r.hexv = c[3:0] + 4'd9;
    end else begin
      r.hexv = 4'd0;
    end
    return r;
  endfunction

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] k;
    case (idx)
      4'd0:    k = CH_QUOTE;
      4'd1:    k = CH_LC_C;
      4'd2:    k = CH_LC_O;
      4'd3:    k = CH_LC_N;
      4'd4:    k = CH_LC_T;
      4'd5:    k = CH_LC_E;
      4'd6:    k = CH_LC_N;
      4'd7:    k = CH_LC_T;
      4'd8:    k = CH_QUOTE;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  function automatic res_t mk_res(input logic [7:0] data, input logic [1:0] kind);
    res_t r;
    r.data = data;
    r.kind = kind;
    return r;
  endfunction

endpackage

// ===== rtl/core/json_content_string_extractor_core.sv =====
// ============================================================================
// json_content_string_extractor_core: "content" string extractor
// Finds the first quoted "content" key in a response text, decodes its
// string value (escapes and \u code points re-encoded as UTF-8) and streams
// the decoded bytes followed by a status result.
// ============================================================================
//
//   channel  handshake           payload
//   -------  ------------------  ---------------------------------
//   input    push / full         in_byte[7:0], in_end
//   result   empty / pop         out_byte[7:0], out_kind[1:0], out_last
//
// A transaction that gives at most one result takes a single engine step, so
// text streams at one byte per cycle while the result queue has room; a
// transaction that gives several results hands them out one at a time through
// the engine's single result port, with an extra flush step when its last
// result follows an earlier one. End-of-text handling replays each held \u
// char as its own step. Synchronous reset returns both queues to empty and
// the decoder to key search; no clearing pass. A full result queue stalls
// the engine, and the input queue (four deep) then raises full.
// ============================================================================
module json_content_string_extractor_core import jcse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last
);

  fq_rd_t fq_rd;
  logic   fq_pop;
  oq_wr_t oq_wr;
  logic   oq_full;

  jcse_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_byte (in_byte),
    .in_end  (in_end),
    .fq_rd   (fq_rd),
    .fq_pop  (fq_pop)
  );

  jcse_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .fq_rd   (fq_rd),
    .fq_pop  (fq_pop),
    .oq_wr   (oq_wr),
    .oq_full (oq_full)
  );

  jcse_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .oq_wr    (oq_wr),
    .oq_full  (oq_full),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_kind (out_kind),
    .out_last (out_last)
  );

endmodule

// ===== rtl/core/jcse_front.sv =====
// ============================================================================
// jcse_front: input queue and byte classifier
// Accepts text bytes, classifies them and holds them in a short queue that
// the engine drains one transaction per cycle when neither busy nor stalled.
// ============================================================================
module jcse_front import jcse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output fq_rd_t     fq_rd,
  input  logic       fq_pop
);

  fitem_t           mem_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FQ_AW:0]   cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;
  fitem_t           wr_item;

  assign full    = (cnt_r == FQ_FULL);
  assign do_push = push && !full;
  assign do_pop  = fq_pop && (cnt_r != '0);

  always_comb begin
    wr_item.cls    = classify(in_byte);
    wr_item.is_end = in_end;
  end

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign fq_rd.valid = (cnt_r != '0);
  assign fq_rd.item  = mem_r[rd_ptr_r];

endmodule

// ===== rtl/core/jcse_back.sv =====
// ============================================================================
// jcse_back: decode engine
// Runs the key search, string decode and end-of-text handling. Each cycle the
// result queue has room it runs one step and passes at most one result on; a
// result waits until the next one or its transaction's end decides its flag.
// ============================================================================
module jcse_back import jcse_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  fq_rd_t fq_rd,
  output logic   fq_pop,
  output oq_wr_t oq_wr,
  input  logic   oq_full
);

  typedef enum logic [6:0] {
    PH_SEARCH = 7'b0000001,
    PH_COLON  = 7'b0000010,
    PH_SPACE  = 7'b0000100,
    PH_BODY   = 7'b0001000,
    PH_ESC    = 7'b0010000,
    PH_HEX    = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  typedef enum logic [2:0] {
    CT_RUN   = 3'b001,
    CT_BURST = 3'b010,
    CT_FLUSH = 3'b100
  } ctl_t;

  typedef enum logic [2:0] {
    OP_ITEM   = 3'b001,
    OP_REPLAY = 3'b010,
    OP_FINISH = 3'b100
  } op_t;

  // Decode state
  phase_t      phase_r, phase_nxt;
  logic [3:0]  kmc_r, kmc_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic [7:0]  held_r [3];
  logic [7:0]  held_nxt [3];
  logic        wrote_r, wrote_nxt;

  // Sequencing state
  ctl_t        ctl_r, ctl_nxt;
  logic        busy_r, busy_nxt;
  op_t         op_r, op_nxt;
  logic        itm_end_r, itm_end_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  rp_r [3];
  logic [7:0]  rp_nxt [3];
  logic [1:0]  rp_n_r, rp_n_nxt;
  logic [1:0]  rp_i_r, rp_i_nxt;
  res_t        brst_r [2];
  res_t        brst_nxt [2];
  logic [1:0]  brst_n_r, brst_n_nxt;
  logic        bst_done_r, bst_done_nxt;
  res_t        hold_r, hold_nxt;
  logic        hold_v_r, hold_v_nxt;

  // Step inputs
  logic        adv;
  logic        run_take;
  logic        ex_en;
  op_t         ex_op;
  cls_t        ex_c;
  logic        cur_end;
  logic [2:0]  cnt_base;
  logic        rp_last;

  // Step outputs
  phase_t      ex_phase;
  logic [3:0]  ex_kmc;
  logic [2:0]  ex_hcnt;
  logic [15:0] ex_cp;
  logic [7:0]  ex_held [3];
  res_t        ex_b [3];
  logic [1:0]  ex_bn;
  logic        ex_done;
  op_t         ex_nop;
  logic        ex_rp_ld;
  logic [3:0]  kmc_step;
  logic [15:0] cp_sh;
  logic [2:0]  room;
  logic [1:0]  k;
  logic        ex_wrote;

  logic        gen_v;
  res_t        gen_res;
  logic        done_now;

  assign adv      = !oq_full;
  assign run_take = adv && (ctl_r == CT_RUN) && !busy_r && fq_rd.valid;
  assign ex_en    = run_take || (adv && (ctl_r == CT_RUN) && busy_r);
  assign fq_pop   = run_take;
  assign cur_end  = run_take ? fq_rd.item.is_end : itm_end_r;
  assign cnt_base = run_take ? 3'd0 : cnt_r;
  assign rp_last  = ({1'b0, rp_i_r} + 3'd1) == {1'b0, rp_n_r};

  always_comb begin
    if (run_take) begin
      ex_op = fq_rd.item.cls.is_zero ? OP_FINISH : OP_ITEM;
      ex_c  = fq_rd.item.cls;
    end else begin
      ex_op = op_r;
      ex_c  = classify(rp_r[rp_i_r]);
    end
  end

  // One decode step
  always_comb begin
    ex_phase = phase_r;
    ex_kmc   = kmc_r;
    ex_hcnt  = hcnt_r;
    ex_cp    = cp_r;
    ex_held  = held_r;
    ex_b[0]  = mk_res(8'h00, KIND_DATA);
    ex_b[1]  = mk_res(8'h00, KIND_DATA);
    ex_b[2]  = mk_res(8'h00, KIND_DATA);
    ex_bn    = 2'd0;
    ex_done  = 1'b0;
    ex_nop   = OP_FINISH;
    ex_rp_ld = 1'b0;
    kmc_step = 4'd0;
    cp_sh    = {cp_r[11:0], ex_c.hexv};
    if (ex_op == OP_FINISH) begin
      ex_done  = 1'b1;
      ex_phase = PH_DONE;
      case (phase_r)
        PH_HEX: begin
          // Emit the escape raw, then replay the held chars as text
          ex_b[0]  = mk_res(CH_BSLASH, KIND_DATA);
          ex_b[1]  = mk_res(CH_LC_U, KIND_DATA);
          ex_bn    = 2'd2;
          ex_rp_ld = 1'b1;
          ex_hcnt  = 3'd0;
          ex_cp    = 16'h0000;
          ex_phase = PH_BODY;
          ex_done  = 1'b0;
          ex_nop   = (hcnt_r == 3'd0) ? OP_FINISH : OP_REPLAY;
        end
        PH_SEARCH: begin
          ex_b[0] = mk_res(8'h00, KIND_NONE);
          ex_bn   = 2'd1;
        end
        PH_COLON, PH_SPACE: begin
          ex_b[0] = mk_res(8'h00, KIND_BAD);
          ex_bn   = 2'd1;
        end
        PH_BODY: begin
          ex_b[0] = mk_res(8'h00, wrote_r ? KIND_DONE : KIND_NONE);
          ex_bn   = 2'd1;
        end
        PH_ESC: begin
          ex_b[0] = mk_res(CH_BSLASH, KIND_DATA);
          ex_b[1] = mk_res(8'h00, KIND_DONE);
          ex_bn   = 2'd2;
        end
        default: begin
        end
      endcase
    end else begin
      ex_done = (ex_op == OP_ITEM) ? !cur_end : 1'b0;
      ex_nop  = ((ex_op == OP_REPLAY) && !rp_last) ? OP_REPLAY : OP_FINISH;
      case (phase_r)
        PH_SEARCH: begin
          if (ex_c.ch == key_char(kmc_r)) begin
            kmc_step = kmc_r + 4'd1;
          end else begin
            kmc_step = ex_c.is_quote ? 4'd1 : 4'd0;
          end
          if (kmc_step >= KEY_LEN) begin
            ex_kmc   = 4'd0;
            ex_phase = PH_COLON;
          end else begin
            ex_kmc = kmc_step;
          end
        end
        PH_COLON: begin
          if (ex_c.is_colon) begin
            ex_phase = PH_SPACE;
          end
        end
        PH_SPACE: begin
          if (!ex_c.is_space) begin
            if (ex_c.is_quote) begin
              ex_phase = PH_BODY;
            end else begin
              ex_b[0]  = mk_res(8'h00, KIND_BAD);
              ex_bn    = 2'd1;
              ex_phase = PH_DONE;
            end
          end
        end
        PH_BODY: begin
          if (ex_c.is_quote) begin
            ex_b[0]  = mk_res(8'h00, wrote_r ? KIND_DONE : KIND_NONE);
            ex_bn    = 2'd1;
            ex_phase = PH_DONE;
          end else if (ex_c.is_bslash) begin
            ex_phase = PH_ESC;
          end else begin
            ex_b[0] = mk_res(ex_c.ch, KIND_DATA);
            ex_bn   = 2'd1;
          end
        end
        PH_ESC: begin
          ex_phase = PH_BODY;
          ex_bn    = 2'd1;
          if (ex_c.is_quote || ex_c.is_bslash) begin
            ex_b[0] = mk_res(ex_c.ch, KIND_DATA);
          end else if (ex_c.ch == CH_LC_N) begin
            ex_b[0] = mk_res(CH_LF, KIND_DATA);
          end else if (ex_c.ch == CH_LC_T) begin
            ex_b[0] = mk_res(CH_TAB, KIND_DATA);
          end else if (ex_c.ch == CH_LC_R) begin
            ex_b[0] = mk_res(CH_CR, KIND_DATA);
          end else if (ex_c.ch == CH_LC_U) begin
            ex_bn    = 2'd0;
            ex_phase = PH_HEX;
            ex_hcnt  = 3'd0;
            ex_cp    = 16'h0000;
          end else begin
            ex_b[0] = mk_res(CH_BSLASH, KIND_DATA);
            ex_b[1] = mk_res(ex_c.ch, KIND_DATA);
            ex_bn   = 2'd2;
          end
        end
        PH_HEX: begin
          if (hcnt_r < 3'd3) begin
            ex_held[hcnt_r[1:0]] = ex_c.ch;
          end
          if (hcnt_r == 3'd3) begin
            // Fourth digit: encode the code point as UTF-8
            if (cp_sh < CP_ONE) begin
              ex_b[0] = mk_res(cp_sh[7:0], KIND_DATA);
              ex_bn   = 2'd1;
            end else if (cp_sh < CP_TWO) begin
              ex_b[0] = mk_res(UTF_LEAD2 | {3'b000, cp_sh[10:6]}, KIND_DATA);
              ex_b[1] = mk_res(UTF_CONT | (cp_sh[7:0] & UTF_MASK), KIND_DATA);
              ex_bn   = 2'd2;
            end else begin
              ex_b[0] = mk_res(UTF_LEAD3 | {4'b0000, cp_sh[15:12]}, KIND_DATA);
              ex_b[1] = mk_res(UTF_CONT | (cp_sh[13:6] & UTF_MASK), KIND_DATA);
              ex_b[2] = mk_res(UTF_CONT | (cp_sh[7:0] & UTF_MASK), KIND_DATA);
              ex_bn   = 2'd3;
            end
            ex_hcnt  = 3'd0;
            ex_cp    = 16'h0000;
            ex_phase = PH_BODY;
          end else begin
            ex_cp   = cp_sh;
            ex_hcnt = hcnt_r + 3'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Clip the step's results to what is left of the per-transaction limit
  always_comb begin
    room = RES_CAP - cnt_base;
    if ({1'b0, ex_bn} <= room) begin
      k = ex_bn;
    end else begin
      k = room[1:0];
    end
    ex_wrote = wrote_r
             || ((k >= 2'd1) && (ex_b[0].kind == KIND_DATA))
             || ((k >= 2'd2) && (ex_b[1].kind == KIND_DATA))
             || ((k == 2'd3) && (ex_b[2].kind == KIND_DATA));
  end

  // Sequencing and result hand-off
  always_comb begin
    phase_nxt    = phase_r;
    kmc_nxt      = kmc_r;
    hcnt_nxt     = hcnt_r;
    cp_nxt       = cp_r;
    held_nxt     = held_r;
    wrote_nxt    = wrote_r;
    ctl_nxt      = ctl_r;
    busy_nxt     = busy_r;
    op_nxt       = op_r;
    itm_end_nxt  = itm_end_r;
    cnt_nxt      = cnt_r;
    rp_nxt       = rp_r;
    rp_n_nxt     = rp_n_r;
    rp_i_nxt     = rp_i_r;
    brst_nxt     = brst_r;
    brst_n_nxt   = brst_n_r;
    bst_done_nxt = bst_done_r;
    hold_nxt     = hold_r;
    hold_v_nxt   = hold_v_r;
    gen_v        = 1'b0;
    gen_res      = ex_b[0];
    done_now     = 1'b0;
    oq_wr        = '0;

    case (ctl_r)
      CT_RUN: begin
        if (ex_en) begin
          phase_nxt = ex_phase;
          kmc_nxt   = ex_kmc;
          hcnt_nxt  = ex_hcnt;
          cp_nxt    = ex_cp;
          held_nxt  = ex_held;
          wrote_nxt = ex_wrote;
          cnt_nxt   = cnt_base + {1'b0, k};
          if (run_take) begin
            itm_end_nxt = fq_rd.item.is_end;
          end
          if (ex_rp_ld) begin
            rp_nxt   = held_r;
            rp_n_nxt = hcnt_r[1:0];
            rp_i_nxt = 2'd0;
          end else if ((ex_op == OP_REPLAY) && !rp_last) begin
            rp_i_nxt = rp_i_r + 2'd1;
          end
          gen_v   = (k != 2'd0);
          gen_res = ex_b[0];
          if (k > 2'd1) begin
            ctl_nxt      = CT_BURST;
            brst_nxt[0]  = ex_b[1];
            brst_nxt[1]  = ex_b[2];
            brst_n_nxt   = k - 2'd1;
            bst_done_nxt = ex_done;
            op_nxt       = ex_nop;
            busy_nxt     = 1'b1;
          end else if (ex_done) begin
            done_now = 1'b1;
            busy_nxt = 1'b0;
          end else begin
            busy_nxt = 1'b1;
            op_nxt   = ex_nop;
          end
        end
      end
      CT_BURST: begin
        if (adv) begin
          gen_v       = 1'b1;
          gen_res     = brst_r[0];
          brst_nxt[0] = brst_r[1];
          brst_n_nxt  = brst_n_r - 2'd1;
          if (brst_n_r == 2'd1) begin
            ctl_nxt = CT_RUN;
            if (bst_done_r) begin
              done_now = 1'b1;
              busy_nxt = 1'b0;
            end
          end
        end
      end
      CT_FLUSH: begin
        if (adv) begin
          oq_wr.push = 1'b1;
          oq_wr.res  = hold_r;
          oq_wr.last = 1'b1;
          hold_v_nxt = 1'b0;
          ctl_nxt    = CT_RUN;
        end
      end
      default: begin
        ctl_nxt = CT_RUN;
      end
    endcase

    // Hold the newest result until the next one shows whether it was the last
    if (gen_v) begin
      if (hold_v_r) begin
        oq_wr.push = 1'b1;
        oq_wr.res  = hold_r;
        oq_wr.last = 1'b0;
        hold_nxt   = gen_res;
        hold_v_nxt = 1'b1;
        if (done_now) begin
          ctl_nxt = CT_FLUSH;
        end
      end else if (done_now) begin
        oq_wr.push = 1'b1;
        oq_wr.res  = gen_res;
        oq_wr.last = 1'b1;
      end else begin
        hold_nxt   = gen_res;
        hold_v_nxt = 1'b1;
      end
    end else if (done_now && hold_v_r) begin
      oq_wr.push = 1'b1;
      oq_wr.res  = hold_r;
      oq_wr.last = 1'b1;
      hold_v_nxt = 1'b0;
    end

    // End of response: drop back to key search
    if (done_now && cur_end) begin
      phase_nxt = PH_SEARCH;
      kmc_nxt   = 4'd0;
      hcnt_nxt  = 3'd0;
      cp_nxt    = 16'h0000;
      wrote_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      kmc_r    <= 4'd0;
      hcnt_r   <= 3'd0;
      cp_r     <= 16'h0000;
      wrote_r  <= 1'b0;
      ctl_r    <= CT_RUN;
      busy_r   <= 1'b0;
      op_r     <= OP_FINISH;
      cnt_r    <= 3'd0;
      brst_n_r <= 2'd0;
      hold_v_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      kmc_r    <= kmc_nxt;
      hcnt_r   <= hcnt_nxt;
      cp_r     <= cp_nxt;
      wrote_r  <= wrote_nxt;
      ctl_r    <= ctl_nxt;
      busy_r   <= busy_nxt;
      op_r     <= op_nxt;
      cnt_r    <= cnt_nxt;
      brst_n_r <= brst_n_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    itm_end_r  <= itm_end_nxt;
    rp_r       <= rp_nxt;
    rp_n_r     <= rp_n_nxt;
    rp_i_r     <= rp_i_nxt;
    brst_r     <= brst_nxt;
    bst_done_r <= bst_done_nxt;
    hold_r     <= hold_nxt;
  end

endmodule

// ===== rtl/core/jcse_outq.sv =====
// ============================================================================
// jcse_outq: result queue
// Buffers decoded results with their last flags and presents the oldest one
// on the result ports.
// ============================================================================
module jcse_outq import jcse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  oq_wr_t     oq_wr,
  output logic       oq_full,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last
);

  typedef struct packed {
    res_t res;
    logic last;
  } oq_ent_t;

  oq_ent_t          mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_AW:0]   cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;
  oq_ent_t          rd_ent;
  oq_ent_t          wr_ent;

  assign oq_full = (cnt_r == OQ_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = oq_wr.push && !oq_full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ent.res  = oq_wr.res;
    wr_ent.last = oq_wr.last;
  end

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_ent;
    end
  end

  assign rd_ent   = mem_r[rd_ptr_r];
  assign out_byte = rd_ent.res.data;
  assign out_kind = rd_ent.res.kind;
  assign out_last = rd_ent.last;

endmodule

// ===== bench/tb_json_content_string_extractor_core.sv =====
// ============================================================================
// tb_json_content_string_extractor_core: content string extractor regression
// Streams response texts into the extractor one byte per transaction and
// checks every result (decoded byte, kind, last flag) against a cycle-free
// decoder kept in the bench. Directed texts cover key search, malformed
// headers, every escape, \u encodings, end-of-text corners, zero bytes, a long
// result stall; then random texts under three sender/receiver idling mixes.
// ============================================================================
module tb_json_content_string_extractor_core;
  import jcse_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int END_SETTLE  = 20;
  localparam logic [71:0] KEY_STR = "\"content\"";

  localparam logic [7:0] WS_SET [6]  = '{CH_SPACE, CH_TAB, CH_LF, 8'h0B, 8'h0C, CH_CR};
  localparam logic [7:0] ESC_SET [5] = '{CH_QUOTE, CH_BSLASH, CH_LC_N, CH_LC_T, CH_LC_R};
  localparam logic [7:0] ODD_HEX [4] = '{CH_QUOTE, CH_BSLASH, "g", "Z"};
  localparam logic [7:0] LEAD_IN [6] = '{"{", CH_SPACE, CH_QUOTE, CH_LC_C, "x", CH_COLON};

  typedef enum logic [2:0] {
    SCAN_KEY, SEEK_COLON, SKIP_WS, IN_STR, IN_ESC, IN_HEX, FINISHED
  } scan_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } decoded_t;

  logic       clk;
  logic       rst_n   = 1'b0;
  logic       push    = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_end  = 1'b0;
  logic       empty;
  logic       pop     = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last;

  // decoder state mirrored in the bench
  scan_phase_e ph;
  logic [3:0]  key_cnt;
  logic [2:0]  hex_cnt;
  logic [15:0] code_pt;
  logic [7:0]  held [3];
  logic        wrote_any;

  decoded_t step_out[$];
  decoded_t decoded_q[$];

  int errors      = 0;
  int cycle_cnt   = 0;
  int live_items  = 0;
  int stall_left  = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  json_content_string_extractor_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .in_end   (in_end),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_kind (out_kind),
    .out_last (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- decoder
  function automatic void put(input logic [7:0] d, input logic [1:0] k);
    decoded_t r;
    // the block drops anything past six results per transaction
    if (step_out.size() < 6) begin
      r.data = d;
      r.kind = k;
      r.last = 1'b0;
      step_out.push_back(r);
      if (k == KIND_DATA) wrote_any = 1'b1;
    end
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    return 4'd0;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void feed_char(input logic [7:0] c);
    logic [15:0] cp;
    case (ph)
      SCAN_KEY: begin
        if (c == KEY_STR[8*(8-key_cnt) +: 8]) key_cnt = key_cnt + 4'd1;
        else key_cnt = (c == CH_QUOTE) ? 4'd1 : 4'd0;
        if (key_cnt >= KEY_LEN) begin
          key_cnt = 4'd0;
          ph = SEEK_COLON;
        end
      end
      SEEK_COLON: if (c == CH_COLON) ph = SKIP_WS;
      SKIP_WS: begin
        if (!is_ws(c)) begin
          if (c == CH_QUOTE) begin
            ph = IN_STR;
          end else begin
            put(8'h00, KIND_BAD);
            ph = FINISHED;
          end
        end
      end
      IN_STR: begin
        if (c == CH_QUOTE) begin
          put(8'h00, wrote_any ? KIND_DONE : KIND_NONE);
          ph = FINISHED;
        end else if (c == CH_BSLASH) begin
          ph = IN_ESC;
        end else begin
          put(c, KIND_DATA);
        end
      end
      IN_ESC: begin
        ph = IN_STR;
        if (c == CH_QUOTE || c == CH_BSLASH) put(c, KIND_DATA);
        else if (c == CH_LC_N) put(CH_LF, KIND_DATA);
        else if (c == CH_LC_T) put(CH_TAB, KIND_DATA);
        else if (c == CH_LC_R) put(CH_CR, KIND_DATA);
        else if (c == CH_LC_U) begin
          ph = IN_HEX;
          hex_cnt = 3'd0;
          code_pt = 16'h0000;
        end else begin
          put(CH_BSLASH, KIND_DATA);
          put(c, KIND_DATA);
        end
      end
      IN_HEX: begin
        if (hex_cnt < 3) held[hex_cnt] = c;
        code_pt = {code_pt[11:0], hex_nibble(c)};
        hex_cnt = hex_cnt + 3'd1;
        if (hex_cnt >= 4) begin
          cp = code_pt;
          if (cp < CP_ONE) begin
            put(cp[7:0], KIND_DATA);
          end else if (cp < CP_TWO) begin
            put(UTF_LEAD2 | {3'b000, cp[10:6]}, KIND_DATA);
            put(UTF_CONT | {2'b00, cp[5:0]}, KIND_DATA);
          end else begin
            put(UTF_LEAD3 | {4'h0, cp[15:12]}, KIND_DATA);
            put(UTF_CONT | {2'b00, cp[11:6]}, KIND_DATA);
            put(UTF_CONT | {2'b00, cp[5:0]}, KIND_DATA);
          end
          hex_cnt = 3'd0;
          code_pt = 16'h0000;
          ph = IN_STR;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void finish_text();
    logic [7:0] saved [3];
    int n;
    // an unfinished \u goes out raw and its held chars are decoded again
    while (ph == IN_HEX) begin
      saved = held;
      n = (hex_cnt > 3) ? 3 : int'(hex_cnt);
      hex_cnt = 3'd0;
      code_pt = 16'h0000;
      put(CH_BSLASH, KIND_DATA);
      put(CH_LC_U, KIND_DATA);
      ph = IN_STR;
      for (int i = 0; i < n; i++) feed_char(saved[i]);
    end
    case (ph)
      SCAN_KEY:             put(8'h00, KIND_NONE);
      SEEK_COLON, SKIP_WS:  put(8'h00, KIND_BAD);
      IN_STR:               put(8'h00, wrote_any ? KIND_DONE : KIND_NONE);
      IN_ESC: begin
        put(CH_BSLASH, KIND_DATA);
        put(8'h00, KIND_DONE);
      end
      default: ;
    endcase
    ph = FINISHED;
  endfunction

  function automatic void clear_decoder();
    ph        = SCAN_KEY;
    key_cnt   = 4'd0;
    hex_cnt   = 3'd0;
    code_pt   = 16'h0000;
    held      = '{8'h00, 8'h00, 8'h00};
    wrote_any = 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] c, input logic fin);
    step_out.delete();
    if (c == 8'h00) finish_text();
    else feed_char(c);
    if (fin) begin
      finish_text();
      clear_decoder();
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
    foreach (step_out[i]) decoded_q.push_back(step_out[i]);
  endfunction

  // --------------------------------------------------------------- checking
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && pop && !empty) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result: byte %h kind %0d last %0d",
                 $time, out_byte, out_kind, out_last);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.data || out_kind !== want.kind || out_last !== want.last) begin
          $display("%0t: mismatch: expected byte %h kind %0d last %0d, got byte %h kind %0d last %0d",
                   $time, want.data, want.kind, want.last, out_byte, out_kind, out_last);
          errors++;
        end
      end
    end
  end

  // receiver: random pops, or a counted hold-off when requested
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------- sending
  // enter and leave on a falling edge; push stays high for the next byte
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_end  <= fin;
    do @(posedge clk); while (full);
    if (ph != FINISHED) live_items++;
    decode_byte(b, fin);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
  endtask

  task automatic wait_results_done();
    push <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void push_text(ref logic [7:0] doc[$], input string s);
    for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'h30 + v;
    return (($urandom_range(1) != 0) ? 8'h41 : 8'h61) + v - 10;
  endfunction

  // mostly well-formed responses with random content; some noise and breakage
  task automatic build_doc(ref logic [7:0] doc[$]);
    int shape, r;
    logic [15:0] cp;
    logic [7:0] c;
    doc.delete();
    shape = $urandom_range(99);
    if (shape < 10) begin
      repeat ($urandom_range(1, 10)) doc.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 3)) doc.push_back(LEAD_IN[$urandom_range(0, 5)]);
    push_text(doc, (shape < 16) ? "\"contnt\"" : "\"content\"");
    if ($urandom_range(4) == 0) doc.push_back(8'($urandom_range(1, 255)));
    if (shape >= 22) doc.push_back(CH_COLON);
    repeat ($urandom_range(0, 2)) doc.push_back(WS_SET[$urandom_range(0, 5)]);
    if (shape < 28) doc.push_back(8'($urandom_range(1, 255)));
    else doc.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      r = $urandom_range(9);
      if (r < 4) begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
        doc.push_back(c);
      end else if (r == 4) begin
        doc.push_back(CH_BSLASH);
        doc.push_back(ESC_SET[$urandom_range(0, 4)]);
      end else if (r == 5) begin
        doc.push_back(CH_BSLASH);
        doc.push_back(8'($urandom_range(1, 255)));
      end else begin
        doc.push_back(CH_BSLASH);
        doc.push_back(CH_LC_U);
        case ($urandom_range(3))
          0:       cp = 16'($urandom_range(0, 16'h7F));
          1:       cp = 16'($urandom_range(16'h80, 16'h7FF));
          default: cp = 16'($urandom);
        endcase
        for (int i = 3; i >= 0; i--) begin
          if (r == 9 && $urandom_range(1) == 0) doc.push_back(ODD_HEX[$urandom_range(0, 3)]);
          else doc.push_back(hex_char(cp[4*i +: 4]));
        end
      end
    end
    r = $urandom_range(9);
    if (r < 6) begin
      doc.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 2)) doc.push_back(8'($urandom));
    end else if (r == 7) begin
      doc.push_back(8'h00);
    end else if (r >= 8) begin
      // text cut off inside an escape
      doc.push_back(CH_BSLASH);
      if (r == 9) begin
        doc.push_back(CH_LC_U);
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(1) != 0) doc.push_back(hex_char(4'($urandom)));
          else doc.push_back(ODD_HEX[$urandom_range(0, 3)]);
        end
      end
    end
  endtask

  // ------------------------------------------------------------------ tests
  task automatic test_key_search();
    send_text("ab", 1'b1);
    send_text("\"\"content\":\"k\"", 1'b1);
    send_text("x\"conten\"content\" : \"z\"", 1'b1);
    send_byte(8'h00, 1'b1);
    wait_results_done();
  endtask

  task automatic test_malformed();
    send_text("\"content\"", 1'b1);
    send_text("\"content\" \t:", 1'b1);
    send_text("\"content\": x\"y\"", 1'b1);
    send_text("\"content\":\"\"", 1'b1);
    wait_results_done();
  endtask

  task automatic test_escapes();
    send_text("\"content\":\"a\\\"\\\\\\n\\t\\r\\q", 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_QUOTE, 1'b1);
    wait_results_done();
  endtask

  task automatic test_unicode();
    send_text("\"content\":\"\\u0041\\u00e9\\u20AC\\uFFFF\\u0000\\u007F", 1'b0);
    send_text("\\u0080\\u07FF\\u0800\\uzz9g\\u\"\\4a\"", 1'b1);
    wait_results_done();
  endtask

  task automatic test_end_cases();
    send_text("\"content\":\"ab\\", 1'b1);
    send_text("\"content\":\"\\u1\"", 1'b1);
    send_text("\"content\":\"\\u\\u0", 1'b1);
    send_text("\"content\":\"xy", 1'b1);
    send_text("\"content\":\"\\u20AC", 1'b1);
    send_text("\"content\":\"\\u", 1'b1);
    wait_results_done();
  endtask

  task automatic test_zero_byte();
    send_text("\"content\":\"a", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("junk\"z", 1'b1);
    send_text("\"content\":\"", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_text("\"content\":\"\\u0000\"", 1'b1);
    send_text("\"content\"", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b1);
    wait_results_done();
  endtask

  // hold the result side long enough for both queues to fill
  task automatic test_full_stall();
    @(posedge clk);
    stall_left = 250;
    @(negedge clk);
    send_text("\"content\":\"", 1'b0);
    repeat (6) send_text("\\uFFFFxy", 1'b0);
    send_byte(CH_QUOTE, 1'b1);
    wait_results_done();
  endtask

  task automatic test_random_docs(input int tx_pct, input int rx_pct, input int n_items);
    logic [7:0] doc[$];
    int goal;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    goal = live_items + n_items;
    while (live_items < goal) begin
      build_doc(doc);
      foreach (doc[i]) send_byte(doc[i], i == doc.size() - 1);
    end
    wait_results_done();
  endtask

  initial begin
    tx_idle_pct = 20;
    rx_idle_pct = 30;
    clear_decoder();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_key_search();
    test_malformed();
    test_escapes();
    test_unicode();
    test_end_cases();
    test_zero_byte();
    test_full_stall();
    test_random_docs(8, 73, 75);
    test_random_docs(73, 8, 75);
    test_random_docs(0, 0, 75);
    repeat (END_SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
